// ===== hdl/assert_macros.svh =====
// assertion macros shared by the escape encoder modules
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== hdl/esc_pkg.sv =====
// types, register codes and character helpers of the c string escape encoder
// no dependencies
package esc_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int COUNT_W    = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MASK_0     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MASK_1     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MASK_2     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MASK_3     = 3'd4;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic [7:0] CH_NUL       = 8'h00;
	localparam logic [7:0] CH_BSLASH    = 8'h5C;
	localparam logic [7:0] CH_X         = 8'h78;
	localparam logic [7:0] CH_PRINT_LO  = 8'h20;
	localparam logic [7:0] CH_PRINT_HI  = 8'h7E;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_A         = 8'h41;

	typedef enum logic [1:0] {
		JOB_TERM,
		JOB_NAMED,
		JOB_HEX,
		JOB_PLAIN
	} job_kind_t;

	typedef struct packed {
		job_kind_t          kind;
		logic [7:0]         data;
		logic [COUNT_W-1:0] count;
	} job_t;

	// letter of a named escape, zero when the byte has none
	function automatic logic [7:0] named_letter(input logic [7:0] c);
		logic [7:0] l;
		case (c)
			8'h07:   l = 8'h61;
			8'h08:   l = 8'h62;
			8'h09:   l = 8'h74;
			8'h0A:   l = 8'h6E;
			8'h0B:   l = 8'h76;
			8'h0C:   l = 8'h66;
			8'h0D:   l = 8'h72;
			8'h1B:   l = 8'h65;
			8'h27:   l = 8'h27;
			8'h22:   l = 8'h22;
			8'h3F:   l = 8'h3F;
			8'h5C:   l = 8'h5C;
			default: l = CH_NUL;
		endcase
		return l;
	endfunction

	// upper-case hex digit
	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		logic [7:0] d;
		if (nib < 4'd10) begin
			d = {4'h0, nib} + CH_ZERO;
		end else begin
			d = {4'h0, nib} - 8'd10 + CH_A;
		end
		return d;
	endfunction

endpackage

// ===== hdl/esc_in_if.sv =====
// source byte channel of the escape encoder
// depends on nothing
interface esc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;

	modport source(output valid, output char_in, input ready);
	modport sink(input valid, input char_in, output ready);
endinterface

// ===== hdl/esc_out_if.sv =====
// escaped output channel of the escape encoder
// uses esc_pkg for the count width
interface esc_out_if;
	logic                        valid;
	logic                        ready;
	logic [7:0]                  out_char;
	logic                        last_of_run;
	logic                        string_end;
	logic [esc_pkg::COUNT_W-1:0] consumed_count;

	modport source(output valid, output out_char, output last_of_run, output string_end,
		output consumed_count, input ready);
	modport sink(input valid, input out_char, input last_of_run, input string_end,
		input consumed_count, output ready);
endinterface

// ===== hdl/esc_cfg_if.sv =====
// register write channel of the escape encoder
// uses esc_pkg for index and data widths
interface esc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [esc_pkg::CFG_IDX_W-1:0]  index;
	logic [esc_pkg::CFG_DATA_W-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ===== hdl/esc_front.sv =====
// front end: registers, byte counter and classification of each source byte
// depends on esc_pkg, esc_in_if, esc_cfg_if
module esc_front (
	input  logic          clk,
	input  logic          arst_n,
	esc_in_if.sink        chars,
	esc_cfg_if.sink       cfg,
	input  logic          q_full,
	output logic          push,
	output esc_pkg::job_t push_job
);

	logic [esc_pkg::COUNT_W-1:0] max_length_q;
	logic [255:0]                mask_q;
	logic [esc_pkg::COUNT_W-1:0] consumed_q;

	logic       accept;
	logic       is_end;
	logic       at_limit;
	logic [7:0] letter;
	logic [7:0] c;

	assign cfg.ready   = 1'b1;
	assign chars.ready = !q_full;
	assign accept      = chars.valid && chars.ready;

	always_comb begin
		c        = chars.char_in;
		letter   = esc_pkg::named_letter(c);
		is_end   = (c == esc_pkg::CH_NUL);
		at_limit = (max_length_q != '0) && (consumed_q >= max_length_q);
		push     = accept && (is_end || !at_limit);
		push_job.count = '0;
		push_job.data  = c;
		if (is_end) begin
			push_job.kind  = esc_pkg::JOB_TERM;
			push_job.count = consumed_q;
		end else if (letter != esc_pkg::CH_NUL) begin
			push_job.kind = esc_pkg::JOB_NAMED;
			push_job.data = letter;
		end else if (c < esc_pkg::CH_PRINT_LO || c > esc_pkg::CH_PRINT_HI || mask_q[c]) begin
			push_job.kind = esc_pkg::JOB_HEX;
		end else begin
			push_job.kind = esc_pkg::JOB_PLAIN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= '0;
			mask_q       <= '0;
			consumed_q   <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					esc_pkg::CFG_MAX_LENGTH: max_length_q <= cfg.data[esc_pkg::COUNT_W-1:0];
					esc_pkg::CFG_MASK_0:     mask_q[63:0]    <= cfg.data;
					esc_pkg::CFG_MASK_1:     mask_q[127:64]  <= cfg.data;
					esc_pkg::CFG_MASK_2:     mask_q[191:128] <= cfg.data;
					esc_pkg::CFG_MASK_3:     mask_q[255:192] <= cfg.data;
					default: ;
				endcase
			end
			if (accept) begin
				if (is_end) begin
					consumed_q <= '0;
				end else if (!at_limit && consumed_q != esc_pkg::COUNT_MAX) begin
					consumed_q <= consumed_q + 1'b1;
				end
			end
		end
	end

endmodule

// ===== hdl/esc_queue.sv =====
// job queue between front and back ends
// depends on esc_pkg and assert_macros.svh
`include "assert_macros.svh"
module esc_queue #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  esc_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          q_valid,
	output esc_pkg::job_t q_job
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	esc_pkg::job_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign q_valid = (count_q != '0);
	assign q_job   = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && q_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CNT_W'(DEPTH), "queue count overflow")
	`ASSERT_ALWAYS(a_ptr_match, clk, arst_n, (rd_q == wr_q) == (count_q == '0 || full), "queue pointers disagree with count")
	`ASSERT_NEVER(a_push_full, clk, arst_n, push && full, "push into full queue")

endmodule

// ===== hdl/esc_back.sv =====
// back end: expands one job into one to four escaped words behind an output register
// depends on esc_pkg, esc_out_if and assert_macros.svh
`include "assert_macros.svh"
module esc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  esc_pkg::job_t q_job,
	output logic          q_pop,
	esc_out_if.source     escaped
);

	logic          job_valid_q;
	esc_pkg::job_t job_q;
	logic [1:0]    step_q;

	logic                        out_valid_q;
	logic [7:0]                  out_char_q;
	logic                        out_last_q;
	logic                        out_end_q;
	logic [esc_pkg::COUNT_W-1:0] out_count_q;

	logic       load;
	logic [7:0] word_char;
	logic       word_last;

	always_comb begin
		word_char = esc_pkg::CH_BSLASH;
		word_last = 1'b0;
		case (job_q.kind)
			esc_pkg::JOB_TERM: begin
				word_char = esc_pkg::CH_NUL;
				word_last = 1'b1;
			end
			esc_pkg::JOB_NAMED: begin
				if (step_q != 2'd0) begin
					word_char = job_q.data;
					word_last = 1'b1;
				end
			end
			esc_pkg::JOB_HEX: begin
				case (step_q)
					2'd0: word_char = esc_pkg::CH_BSLASH;
					2'd1: word_char = esc_pkg::CH_X;
					2'd2: word_char = esc_pkg::hex_digit(job_q.data[7:4]);
					default: begin
						word_char = esc_pkg::hex_digit(job_q.data[3:0]);
						word_last = 1'b1;
					end
				endcase
			end
			default: begin
				word_char = job_q.data;
				word_last = 1'b1;
			end
		endcase
	end

	assign load  = job_valid_q && (!out_valid_q || escaped.ready);
	assign q_pop = q_valid && (!job_valid_q || (load && word_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				job_valid_q <= 1'b1;
				step_q      <= '0;
			end else if (load && word_last) begin
				job_valid_q <= 1'b0;
			end else if (load) begin
				step_q <= step_q + 1'b1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (escaped.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_job;
		end
		if (load) begin
			out_char_q  <= word_char;
			out_last_q  <= word_last;
			out_end_q   <= (job_q.kind == esc_pkg::JOB_TERM);
			out_count_q <= (job_q.kind == esc_pkg::JOB_TERM) ? job_q.count : '0;
		end
	end

	assign escaped.valid          = out_valid_q;
	assign escaped.out_char       = out_char_q;
	assign escaped.last_of_run    = out_last_q;
	assign escaped.string_end     = out_end_q;
	assign escaped.consumed_count = out_count_q;

	`ASSERT_ALWAYS(a_term_word, clk, arst_n, out_valid_q |-> ((out_char_q == esc_pkg::CH_NUL) == out_end_q), "zero word without terminator flag")
	`ASSERT_ALWAYS(a_end_last, clk, arst_n, (out_valid_q && out_end_q) |-> out_last_q, "terminator not last of run")
	`ASSERT_ALWAYS(a_step_range, clk, arst_n, (job_valid_q && job_q.kind != esc_pkg::JOB_HEX) |-> (step_q <= 2'd1), "step beyond job length")

endmodule

// ===== hdl/c_string_escape_encoder.sv =====
// top level of the c string escape encoder
// depends on esc_pkg, the three channel interfaces, esc_front, esc_queue, esc_back
//
// Each source byte on chars comes out on escaped as one to four words: a byte with a named
// escape (control, quote, ? or backslash) takes two words (backslash, letter), a
// non-printable or mask-selected byte four (backslash, x, two upper-case hex digits), any
// other printable byte one, and a zero byte one terminator word carrying the converted byte
// count of the string. The escaped channel moves one word per cycle while escaped.ready is
// high, also from one job to the next. The front end takes a byte every cycle while the job
// queue of QUEUE_DEPTH entries has room; bytes past a nonzero max_length are dropped without
// output. Registers: index 0 max_length (0 means no limit), indexes 1 to 4 the 256-bit hex
// mask, lowest byte values first. Write registers only while no word is outstanding.
module c_string_escape_encoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	esc_in_if.sink    chars,
	esc_out_if.source escaped,
	esc_cfg_if.sink   cfg
);

	logic          push;
	esc_pkg::job_t push_job;
	logic          q_full;
	logic          q_pop;
	logic          q_valid;
	esc_pkg::job_t q_job;

	esc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.chars    (chars),
		.cfg      (cfg),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	esc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.q_valid  (q_valid),
		.q_job    (q_job)
	);

	esc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_job   (q_job),
		.q_pop   (q_pop),
		.escaped (escaped)
	);

endmodule
